// File: sv/nnzs_pkg.sv
package nnzs_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int CHANNELS   = 3;

    localparam int COORD_W = 12;
    localparam int SIZE_W  = 9;
    localparam int OSIZE_W = 12;
    localparam int CEN_W   = 17;
    localparam int ZOOM_W  = 16;
    localparam int PIX_W   = 24;
    localparam int OUTC_W  = 8;
    localparam int CROP_W  = SIZE_W + 16;
    localparam int POS_W   = SIZE_W + CEN_W;
    localparam int HALF_W  = CROP_W + 7;
    localparam int START_W = 18;
    localparam int OFS_W   = CROP_W - 8;
    localparam int NUM_W   = COORD_W + CROP_W;
    localparam int MAP_LAT = OFS_W + 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_OUT_WIDTH  = 3'd2,
        REG_OUT_HEIGHT = 3'd3,
        REG_CENTER_X   = 3'd4,
        REG_CENTER_Y   = 3'd5,
        REG_ZOOM       = 3'd6
    } reg_idx_t;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } req_t;

    typedef struct packed {
        logic                 req;
        logic                 status;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [PIX_W-1:0]     pix;
    } side_t;

endpackage

// File: sv/nnzs_crop_calc.sv
module nnzs_crop_calc (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 go,
    input  logic [nnzs_pkg::SIZE_W-1:0]          size,
    input  logic [nnzs_pkg::CEN_W-1:0]           centre,
    input  logic [nnzs_pkg::ZOOM_W-1:0]          zoom,
    output logic [nnzs_pkg::CROP_W-1:0]          crop8,
    output logic signed [nnzs_pkg::START_W-1:0]  start,
    output logic                                 busy
);
    import nnzs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_POS,
        ST_FIN
    } state_t;

    state_t              state_reg;
    logic [4:0]          cnt_reg;
    logic [CROP_W-1:0]   num_reg;
    logic [ZOOM_W-1:0]   rem_reg;
    logic [CROP_W-1:0]   q_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [CEN_W-1:0]    cen_reg;
    logic [ZOOM_W-1:0]   zoom_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CROP_W-1:0]   crop_reg;
    logic signed [START_W-1:0] start_reg;

    logic [ZOOM_W:0]     rem_sh;
    logic                fits;
    logic [HALF_W-1:0]   half;
    logic [HALF_W-1:0]   pos_ext;
    logic [HALF_W-1:0]   dpos;
    logic [HALF_W-1:0]   dneg;

    assign rem_sh  = {rem_reg, num_reg[CROP_W-1]};
    assign fits    = rem_sh >= {1'b0, zoom_reg};
    assign half    = {q_reg, 7'b0};
    assign pos_ext = HALF_W'(pos_reg);
    assign dpos    = pos_ext - half;
    assign dneg    = half - pos_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else if (go)
        begin
            state_reg <= ST_DIV;
            cnt_reg   <= 5'(CROP_W - 1);
            num_reg   <= {size, 16'b0};
            rem_reg   <= '0;
            q_reg     <= '0;
            size_reg  <= size;
            cen_reg   <= centre;
            zoom_reg  <= zoom;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                end
                ST_DIV:
                begin
                    num_reg <= {num_reg[CROP_W-2:0], 1'b0};
                    if (fits)
                    begin
                        rem_reg <= ZOOM_W'(rem_sh - {1'b0, zoom_reg});
                    end
                    else
                    begin
                        rem_reg <= rem_sh[ZOOM_W-1:0];
                    end
                    q_reg   <= {q_reg[CROP_W-2:0], fits};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= ST_POS;
                    end
                end
                ST_POS:
                begin
                    pos_reg   <= POS_W'(size_reg) * POS_W'(cen_reg);
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    crop_reg <= q_reg;
                    if (pos_ext >= half)
                    begin
                        start_reg <= signed'(START_W'(dpos >> 16));
                    end
                    else
                    begin
                        start_reg <= -signed'(START_W'(dneg >> 16));
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign crop8 = crop_reg;
    assign start = start_reg;
    assign busy  = state_reg != ST_IDLE;

endmodule

// File: sv/nnzs_map_pipe.sv
module nnzs_map_pipe (
    input  logic                                 clk,
    input  logic [nnzs_pkg::COORD_W-1:0]         p,
    input  logic [nnzs_pkg::CROP_W-1:0]          crop8,
    input  logic signed [nnzs_pkg::START_W-1:0]  start,
    input  logic [nnzs_pkg::SIZE_W-1:0]          size,
    input  logic [nnzs_pkg::OSIZE_W-1:0]         osize,
    output logic [nnzs_pkg::SIZE_W-1:0]          src
);
    import nnzs_pkg::*;

    logic [NUM_W-1:0]  rem_reg [0:OFS_W];
    logic [OFS_W-1:0]  q_reg   [0:OFS_W];
    logic [SIZE_W-1:0] src_reg;
    logic [NUM_W-1:0]  den;

    logic signed [START_W:0] sum;
    logic signed [START_W:0] lim;

    assign den = NUM_W'({osize, 8'b0});

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= NUM_W'(p) * NUM_W'(crop8);
        q_reg[0]   <= '0;
    end

    for (genvar i = 0; i < OFS_W; i++)
    begin : g_div
        localparam int K = OFS_W - 1 - i;
        logic [NUM_W-1:0] dsh;
        assign dsh = den << K;

        always_ff @(posedge clk)
        begin
            if (rem_reg[i] >= dsh)
            begin
                rem_reg[i+1] <= rem_reg[i] - dsh;
                q_reg[i+1]   <= q_reg[i] | (OFS_W'(1) << K);
            end
            else
            begin
                rem_reg[i+1] <= rem_reg[i];
                q_reg[i+1]   <= q_reg[i];
            end
        end
    end

    assign sum = (START_W+1)'(start) + signed'({2'b0, q_reg[OFS_W]});
    assign lim = signed'((START_W+1)'(size) - (START_W+1)'(1));

    always_ff @(posedge clk)
    begin
        if (sum < 0)
        begin
            src_reg <= '0;
        end
        else if (sum > lim)
        begin
            src_reg <= SIZE_W'(lim);
        end
        else
        begin
            src_reg <= SIZE_W'(sum);
        end
    end

    assign src = src_reg;

endmodule

// File: sv/nearest_neighbor_zoom_scaler.sv
// Nearest-neighbor crop and zoom scaler with an internal frame store.
// Input: an item is taken when start is high and busy is low. req_type 0
// stores pixel_in at (coord_x, coord_y); req_type 1 reads output pixel
// (coord_x, coord_y) through the crop window centered at center_x/center_y.
// Output: one result per item, shown for one cycle with done high; the
// receiver cannot stall, so results simply stream out in item order.
// Throughput is one item per cycle while busy is low, set by a fully
// pipelined 12x25 multiply followed by a 17-stage restoring divider, one
// quotient bit per stage, per axis.
// Frame store: one write or one read per cycle; writes and reads use the
// same pipeline stage, so a read always sees every earlier write.
// Config: APB registers at byte offsets 0x00..0x18. After reset and after
// every register write, busy stays high while the crop size and crop start
// are recomputed by a serial divider (one bit per cycle).
// Reset: clears the pipeline valids and loads register defaults; frame store
// contents are undefined until written.
module nearest_neighbor_zoom_scaler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [nnzs_pkg::COORD_W-1:0]      coord_x,
    input  logic [nnzs_pkg::COORD_W-1:0]      coord_y,
    input  logic [nnzs_pkg::PIX_W-1:0]        pixel_in,
    output logic                              done,
    output logic [nnzs_pkg::PIX_W-1:0]        pixel_out,
    output logic [nnzs_pkg::OUTC_W-1:0]       source_x,
    output logic [nnzs_pkg::OUTC_W-1:0]       source_y,
    output logic                              status,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nnzs_pkg::ADDR_W-1:0]       paddr,
    input  logic [nnzs_pkg::DATA_W-1:0]       pwdata,
    output logic [nnzs_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import nnzs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (CHANNELS >= 3) ? PIX_W : 8 * CHANNELS;

    logic [SIZE_W-1:0]  src_width_reg;
    logic [SIZE_W-1:0]  src_height_reg;
    logic [OSIZE_W-1:0] out_width_reg;
    logic [OSIZE_W-1:0] out_height_reg;
    logic [CEN_W-1:0]   center_x_reg;
    logic [CEN_W-1:0]   center_y_reg;
    logic [ZOOM_W-1:0]  zoom_reg;
    logic               go_reg;

    logic               wr_en;
    reg_idx_t           idx;
    logic [SIZE_W-1:0]  eff_w;
    logic [SIZE_W-1:0]  eff_h;
    logic [ZOOM_W-1:0]  eff_z;
    logic               busy_x;
    logic               busy_y;
    logic               accept;
    logic               in_status;

    logic [CROP_W-1:0]         crop_x;
    logic [CROP_W-1:0]         crop_y;
    logic signed [START_W-1:0] start_x;
    logic signed [START_W-1:0] start_y;
    logic [SIZE_W-1:0]         map_x;
    logic [SIZE_W-1:0]         map_y;

    logic               valid_reg [0:MAP_LAT];
    side_t              side_reg [0:MAP_LAT];
    logic               mvalid_reg;
    side_t              mside_reg;
    logic [OUTC_W-1:0]  mx_reg;
    logic [OUTC_W-1:0]  my_reg;
    logic [SW-1:0]      rd_reg;
    logic [SW-1:0]      mem [0:DEPTH-1];

    logic [COORD_W-1:0] sel_x;
    logic [COORD_W-1:0] sel_y;
    logic [23:0]        addr_full;
    logic [AW-1:0]      addr;
    side_t              side_last;
    logic               mem_ok;

    logic               done_reg;
    logic [PIX_W-1:0]   pixel_out_reg;
    logic [OUTC_W-1:0]  source_x_reg;
    logic [OUTC_W-1:0]  source_y_reg;
    logic               status_reg;

    // config port
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 9'd256;
            src_height_reg <= 9'd256;
            out_width_reg  <= 12'd256;
            out_height_reg <= 12'd256;
            center_x_reg   <= 17'd32768;
            center_y_reg   <= 17'd32768;
            zoom_reg       <= 16'd512;
            go_reg         <= 1'b1;
        end
        else
        begin
            go_reg <= wr_en;
            if (wr_en)
            begin
                unique case (idx)
                    REG_SRC_WIDTH:  src_width_reg  <= pwdata[SIZE_W-1:0];
                    REG_SRC_HEIGHT: src_height_reg <= pwdata[SIZE_W-1:0];
                    REG_OUT_WIDTH:  out_width_reg  <= pwdata[OSIZE_W-1:0];
                    REG_OUT_HEIGHT: out_height_reg <= pwdata[OSIZE_W-1:0];
                    REG_CENTER_X:   center_x_reg   <= pwdata[CEN_W-1:0];
                    REG_CENTER_Y:   center_y_reg   <= pwdata[CEN_W-1:0];
                    REG_ZOOM:       zoom_reg       <= pwdata[ZOOM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SRC_WIDTH:  prdata = DATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = DATA_W'(src_height_reg);
            REG_OUT_WIDTH:  prdata = DATA_W'(out_width_reg);
            REG_OUT_HEIGHT: prdata = DATA_W'(out_height_reg);
            REG_CENTER_X:   prdata = DATA_W'(center_x_reg);
            REG_CENTER_Y:   prdata = DATA_W'(center_y_reg);
            REG_ZOOM:       prdata = DATA_W'(zoom_reg);
            default:        prdata = '0;
        endcase
    end

    // effective sizes
    always_comb
    begin
        priority if (src_width_reg == '0)
            eff_w = SIZE_W'(1);
        else if (src_width_reg > SIZE_W'(MAX_WIDTH))
            eff_w = SIZE_W'(MAX_WIDTH);
        else
            eff_w = src_width_reg;

        priority if (src_height_reg == '0)
            eff_h = SIZE_W'(1);
        else if (src_height_reg > SIZE_W'(MAX_HEIGHT))
            eff_h = SIZE_W'(MAX_HEIGHT);
        else
            eff_h = src_height_reg;

        eff_z = (zoom_reg == '0) ? ZOOM_W'(1) : zoom_reg;
    end

    nnzs_crop_calc u_calc_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go_reg),
        .size   (eff_w),
        .centre (center_x_reg),
        .zoom   (eff_z),
        .crop8  (crop_x),
        .start  (start_x),
        .busy   (busy_x)
    );

    nnzs_crop_calc u_calc_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go_reg),
        .size   (eff_h),
        .centre (center_y_reg),
        .zoom   (eff_z),
        .crop8  (crop_y),
        .start  (start_y),
        .busy   (busy_y)
    );

    assign busy   = go_reg | busy_x | busy_y;
    assign accept = start & ~busy;

    always_comb
    begin
        if (req_type == REQ_WRITE)
            in_status = (coord_x >= COORD_W'(eff_w)) || (coord_y >= COORD_W'(eff_h));
        else
            in_status = (coord_x >= out_width_reg) || (coord_y >= out_height_reg);
    end

    // sideband pipeline, aligned with the mapper
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= MAP_LAT; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int k = 1; k <= MAP_LAT; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0].req    <= req_type;
        side_reg[0].status <= in_status;
        side_reg[0].cx     <= coord_x;
        side_reg[0].cy     <= coord_y;
        side_reg[0].pix    <= pixel_in;
        for (int k = 1; k <= MAP_LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    nnzs_map_pipe u_map_x (
        .clk   (clk),
        .p     (side_reg[0].cx),
        .crop8 (crop_x),
        .start (start_x),
        .size  (eff_w),
        .osize (out_width_reg),
        .src   (map_x)
    );

    nnzs_map_pipe u_map_y (
        .clk   (clk),
        .p     (side_reg[0].cy),
        .crop8 (crop_y),
        .start (start_y),
        .size  (eff_h),
        .osize (out_height_reg),
        .src   (map_y)
    );

    // frame store stage
    assign side_last = side_reg[MAP_LAT];
    assign sel_x     = (side_last.req == REQ_READ) ? COORD_W'(map_x) : side_last.cx;
    assign sel_y     = (side_last.req == REQ_READ) ? COORD_W'(map_y) : side_last.cy;
    assign addr_full = 24'(sel_y) * 24'(MAX_WIDTH) + 24'(sel_x);
    assign addr      = addr_full[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (valid_reg[MAP_LAT] && (side_last.req == REQ_WRITE) && !side_last.status)
        begin
            mem[addr] <= side_last.pix[SW-1:0];
        end
        rd_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg <= 1'b0;
        end
        else
        begin
            mvalid_reg <= valid_reg[MAP_LAT];
        end
    end

    always_ff @(posedge clk)
    begin
        mside_reg <= side_last;
        mx_reg    <= sel_x[OUTC_W-1:0];
        my_reg    <= sel_y[OUTC_W-1:0];
    end

    // result stage
    assign mem_ok = !mside_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mvalid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= mside_reg.status;
        pixel_out_reg <= (mem_ok && mside_reg.req == REQ_READ) ? PIX_W'(rd_reg) : '0;
        source_x_reg  <= mem_ok ? mx_reg : '0;
        source_y_reg  <= mem_ok ? my_reg : '0;
    end

    assign done      = done_reg;
    assign pixel_out = pixel_out_reg;
    assign source_x  = source_x_reg;
    assign source_y  = source_y_reg;
    assign status    = status_reg;

    // checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(MAP_LAT + 3) done)
        else $error("result missing after transfer");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(mvalid_reg))
        else $error("result without item");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (pixel_out == '0 && source_x == '0 && source_y == '0))
        else $error("flagged result carries data");

    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> busy)
        else $error("busy low after register write");

endmodule

// File: test/nearest_neighbor_zoom_scaler_test.sv
module nearest_neighbor_zoom_scaler_test;
    import nnzs_pkg::*;

    typedef struct {
        logic [PIX_W-1:0]  pix;
        logic [OUTC_W-1:0] sx;
        logic [OUTC_W-1:0] sy;
        logic              st;
    } zoom_result_t;

    typedef struct {
        req_t              req;
        logic [11:0]       x;
        logic [11:0]       y;
        logic [23:0]       pix;
        bit                typed;
        zoom_result_t      res;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              req_type;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [PIX_W-1:0]  pixel_in;
    logic              done;
    logic [PIX_W-1:0]  pixel_out;
    logic [OUTC_W-1:0] source_x;
    logic [OUTC_W-1:0] source_y;
    logic              status;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic [23:0]       pixel_mem [0:65535];
    bit                pixel_written [0:65535];
    int unsigned       regs [0:6];
    zoom_result_t      pending_results [$];
    int                errors;
    int                cycles_idle;
    int                idle_pct;

    nearest_neighbor_zoom_scaler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .pixel_in  (pixel_in),
        .done      (done),
        .pixel_out (pixel_out),
        .source_x  (source_x),
        .source_y  (source_y),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned eff_size(int unsigned s);
        if (s == 0)
            return 1;
        return (s > 256) ? 256 : s;
    endfunction

    function automatic int unsigned zoom_axis(int unsigned size, int unsigned centre,
                                              int unsigned z, int unsigned osize,
                                              int unsigned p);
        longint crop8;
        longint pos;
        longint half;
        longint origin;
        longint src;
        crop8 = (longint'(size) << 16) / z;
        pos   = longint'(size) * centre;
        half  = crop8 << 7;
        if (pos >= half)
            origin = (pos - half) >>> 16;
        else
            origin = -((half - pos) >>> 16);
        src = origin + (longint'(p) * crop8) / (longint'(osize) << 8);
        if (src < 0)
            src = 0;
        if (src > size - 1)
            src = size - 1;
        return int'(src);
    endfunction

    // returns source column/row of an in-range read
    function automatic void zoom_map(int unsigned x, int unsigned y,
                                     output int unsigned sx, output int unsigned sy);
        int unsigned z;
        z  = (regs[REG_ZOOM] == 0) ? 1 : regs[REG_ZOOM];
        sx = zoom_axis(eff_size(regs[REG_SRC_WIDTH]), regs[REG_CENTER_X], z,
                       regs[REG_OUT_WIDTH], x);
        sy = zoom_axis(eff_size(regs[REG_SRC_HEIGHT]), regs[REG_CENTER_Y], z,
                       regs[REG_OUT_HEIGHT], y);
    endfunction

    function automatic zoom_result_t zoom_predict(req_t req, int unsigned x,
                                                  int unsigned y, logic [23:0] pix);
        zoom_result_t r;
        int unsigned sx;
        int unsigned sy;
        r = '{pix: '0, sx: '0, sy: '0, st: 1'b0};
        if (req == REQ_WRITE)
        begin
            if (x >= eff_size(regs[REG_SRC_WIDTH]) || y >= eff_size(regs[REG_SRC_HEIGHT]))
                r.st = 1'b1;
            else
            begin
                pixel_mem[y * 256 + x]     = pix;
                pixel_written[y * 256 + x] = 1'b1;
                r.sx = OUTC_W'(x);
                r.sy = OUTC_W'(y);
            end
        end
        else if (x >= regs[REG_OUT_WIDTH] || y >= regs[REG_OUT_HEIGHT])
            r.st = 1'b1;
        else
        begin
            zoom_map(x, y, sx, sy);
            r.sx  = OUTC_W'(sx);
            r.sy  = OUTC_W'(sy);
            r.pix = pixel_mem[sy * 256 + sx];
        end
        return r;
    endfunction

    task automatic send_one(req_t req, int unsigned x, int unsigned y, logic [23:0] pix,
                            bit typed, zoom_result_t typed_res);
        zoom_result_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        req_type <= req;
        coord_x  <= COORD_W'(x);
        coord_y  <= COORD_W'(y);
        pixel_in <= pix;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        cycles_idle = 0;
        r = zoom_predict(req, x, y, pix);
        pending_results = {pending_results, (typed ? typed_res : r)};
    endtask

    // a read is only sent once its source pixel has been written
    task automatic send_item(req_t req, int unsigned x, int unsigned y, logic [23:0] pix,
                             bit typed = 0, zoom_result_t typed_res = '{0, 0, 0, 0});
        int unsigned sx;
        int unsigned sy;
        if (req == REQ_READ && x < regs[REG_OUT_WIDTH] && y < regs[REG_OUT_HEIGHT])
        begin
            zoom_map(x, y, sx, sy);
            if (!pixel_written[sy * 256 + sx])
                send_one(REQ_WRITE, sx, sy, 24'($urandom_range(24'hFFFFFF)), 0, typed_res);
        end
        send_one(req, x, y, pix, typed, typed_res);
    endtask

    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned value);
        @(negedge clk);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        regs[idx] = value;
        cycles_idle = 0;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_items(int count);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        req_t req;
        repeat (count)
        begin
            req = req_t'($urandom_range(1));
            if (req == REQ_WRITE)
            begin
                w = eff_size(regs[REG_SRC_WIDTH]);
                h = eff_size(regs[REG_SRC_HEIGHT]);
            end
            else
            begin
                w = regs[REG_OUT_WIDTH];
                h = regs[REG_OUT_HEIGHT];
            end
            if ($urandom_range(99) < 85 && w != 0 && h != 0)
            begin
                x = $urandom_range(w - 1);
                y = $urandom_range(h - 1);
            end
            else
            begin
                x = $urandom_range(4095);
                y = $urandom_range(4095);
            end
            send_item(req, x, y, 24'($urandom_range(24'hFFFFFF)));
        end
    endtask

    always @(posedge clk)
    begin
        zoom_result_t e;
        cycles_idle++;
        if (cycles_idle >= 5000)
        begin
            $display("simulation failed");
            $finish;
        end
        if (rst_n && done)
        begin
            cycles_idle = 0;
            if (pending_results.size() == 0)
            begin
                $error("unexpected transfer on result port");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (pixel_out !== e.pix)
                begin
                    $error("pixel_out expected %h got %h", e.pix, pixel_out);
                    errors++;
                end
                if (source_x !== e.sx)
                begin
                    $error("source_x expected %0d got %0d", e.sx, source_x);
                    errors++;
                end
                if (source_y !== e.sy)
                begin
                    $error("source_y expected %0d got %0d", e.sy, source_y);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $error("status expected %0d got %0d", e.st, status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t rows [$];
        int unsigned cfg [0:6];
        int unsigned settings [0:6][0:6];
        rows = '{
            '{REQ_WRITE, 0,    0,    24'hFFFFFF, 1, '{24'h0, 0,   0,   0}},
            '{REQ_WRITE, 255,  255,  24'h000000, 1, '{24'h0, 255, 255, 0}},
            '{REQ_WRITE, 256,  0,    24'hABCDEF, 1, '{24'h0, 0,   0,   1}},
            '{REQ_WRITE, 0,    256,  24'hABCDEF, 1, '{24'h0, 0,   0,   1}},
            '{REQ_WRITE, 4095, 4095, 24'hFFFFFF, 1, '{24'h0, 0,   0,   1}},
            '{REQ_WRITE, 64,   64,   24'h123456, 1, '{24'h0, 64,  64,  0}},
            '{REQ_READ,  0,    0,    24'hFFFFFF, 1, '{24'h123456, 64, 64, 0}},
            '{REQ_READ,  256,  0,    24'h0,      1, '{24'h0, 0,   0,   1}},
            '{REQ_READ,  0,    256,  24'h0,      1, '{24'h0, 0,   0,   1}},
            '{REQ_READ,  4095, 4095, 24'h0,      1, '{24'h0, 0,   0,   1}},
            '{REQ_WRITE, 255,  0,    24'h5A5A5A, 0, '{24'h0, 0,   0,   0}},
            '{REQ_WRITE, 0,    255,  24'hA5A5A5, 0, '{24'h0, 0,   0,   0}},
            '{REQ_READ,  255,  255,  24'h0,      0, '{24'h0, 0,   0,   0}},
            '{REQ_READ,  255,  0,    24'h0,      0, '{24'h0, 0,   0,   0}},
            '{REQ_READ,  0,    255,  24'h0,      0, '{24'h0, 0,   0,   0}},
            '{REQ_READ,  128,  128,  24'h0,      0, '{24'h0, 0,   0,   0}}
        };
        settings = '{
            '{256, 256, 256,  256,  32768, 32768,  256},
            '{1,   1,   1,    1,    0,     0,      65535},
            '{0,   300, 4095, 4095, 65536, 131071, 1},
            '{100, 37,  640,  480,  20000, 50000,  384},
            '{511, 256, 0,    17,   32768, 0,      0},
            '{13,  200, 37,   4095, 65535, 1,      1000},
            '{0,   0,   0,    0,    0,     0,      0}
        };
        errors      = 0;
        cycles_idle = 0;
        idle_pct    = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = 1'b0;
        coord_x  = '0;
        coord_y  = '0;
        pixel_in = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        regs = '{256, 256, 256, 256, 32768, 32768, 512};
        foreach (pixel_written[i])
            pixel_written[i] = 1'b0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_item(rows[i].req, rows[i].x, rows[i].y, rows[i].pix,
                      rows[i].typed, rows[i].res);
        random_items(200);

        for (int p = 0; p < 7; p++)
        begin
            drain();
            cfg = settings[p];
            if (p == 6)
                cfg = '{$urandom_range(511), $urandom_range(511), $urandom_range(4095),
                        $urandom_range(4095), $urandom_range(131071),
                        $urandom_range(131071), $urandom_range(65535)};
            for (int r = 0; r < 7; r++)
                write_reg(reg_idx_t'(r), cfg[r]);
            unique case (p % 4)
                0: idle_pct = 0;
                1: idle_pct = 56;
                2: idle_pct = 0;
                default: idle_pct = 22;
            endcase
            random_items(215);
        end

        @(negedge clk);
        start <= 1'b0;
        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
